### src/smeu_pkg.sv
`timescale 1ns / 1ps
// smeu_pkg: shared types and codes for the stack machine execute unit.
// No dependencies.
package smeu_pkg;

    localparam int SMEU_STACK_DEPTH  = 1024;
    localparam int SMEU_RETURN_DEPTH = 1024;

    localparam logic [7:0] OP_NOP    = 8'd0;
    localparam logic [7:0] OP_ADD    = 8'd1;
    localparam logic [7:0] OP_SUB    = 8'd2;
    localparam logic [7:0] OP_OUT    = 8'd3;
    localparam logic [7:0] OP_PUSH   = 8'd4;
    localparam logic [7:0] OP_LSTACK = 8'd5;
    localparam logic [7:0] OP_SSTACK = 8'd6;
    localparam logic [7:0] OP_CALL   = 8'd7;
    localparam logic [7:0] OP_RET    = 8'd8;
    localparam logic [7:0] OP_HALT   = 8'd9;
    localparam logic [7:0] OP_CMP    = 8'd10;
    localparam logic [7:0] OP_JZ     = 8'd11;
    localparam logic [7:0] OP_JP     = 8'd12;
    localparam logic [7:0] OP_POP    = 8'd13;
    localparam logic [7:0] OP_POPU   = 8'd14;
    localparam logic [7:0] OP_DUP    = 8'd15;
    localparam logic [7:0] OP_JNZ    = 8'd16;

    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_BOOL = 2'd1;
    localparam logic [1:0] TAG_NONE = 2'd2;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_TYPE   = 3'd1;
    localparam logic [2:0] ERR_UNSUP  = 3'd2;
    localparam logic [2:0] ERR_OPCODE = 3'd3;
    localparam logic [2:0] ERR_STACK  = 3'd4;

    typedef struct packed {
        logic [7:0]         action;
        logic [31:0]        operand_a;
        logic [31:0]        operand_b;
        logic signed [31:0] const_value;
    } item_t;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic               out_valid;
        logic signed [63:0] out_value;
        logic [1:0]         out_type;
        logic               halted;
        logic [2:0]         error;
    } result_t;

    typedef struct packed {
        logic [1:0]  tag;
        logic [63:0] val;
    } entry_t;

endpackage

### src/smeu_ram.sv
`timescale 1ns / 1ps
// smeu_ram: single-port-write, single-port-read synchronous RAM with registered
// read data, with write-to-read bypass on a same-address collision.
module smeu_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] q_reg;
    logic [W-1:0] byp_reg;
    logic         hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            byp_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = hit_reg ? byp_reg : q_reg;

endmodule

### src/stack_machine_execute_unit.sv
`timescale 1ns / 1ps
// stack_machine_execute_unit: top level, executes one decoded instruction per item.
// Depends on smeu_pkg and smeu_ram.
//
// Usage: an instruction enters on item/item_valid/item_ready; exactly one
// result leaves on result/result_valid/result_ready for every item, in order.
// The operand stack and the return stack live in synchronous RAMs with
// registered read data. Return frames are stored as one row per call.
// Stack reads are issued at accept; ADD, SUB and CMP issue their second read
// before they execute. The result is registered in the output register.
// Throughput: one item per cycle for single-read instructions while the output
// is not stalled; ADD, SUB and CMP hold the next item back during their second
// read, set by the single read port of the operand stack RAM. The next item is
// taken in the cycle the current one executes; its addresses are formed from
// the updated pointers and a RAM bypass covers a read of the entry being written.
// Reset: pointers and pc go to zero, the machine runs; RAM contents are
// undefined until written. After HALT every item returns the same pc with
// halted set.
// Stall: a result waits in the output register; the item behind it is held
// in execute until the register frees, then input accepts resume.
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int STACK_DEPTH  = SMEU_STACK_DEPTH,
    parameter int RETURN_DEPTH = SMEU_RETURN_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int RROWS = RETURN_DEPTH / 2;
    localparam int RPW   = $clog2(RROWS + 1);
    localparam int RAW   = $clog2(RROWS);
    localparam int RW    = 32 + SPW;

    function automatic logic fault_of(input logic [7:0] op, input logic [31:0] a,
                                      input logic [SPW-1:0] sp, input logic [SPW-1:0] fb,
                                      input logic [RPW-1:0] rpp);
        logic [32:0] idx;
        logic        f;
        idx = 33'(a) + 33'(fb);
        f   = 1'b0;
        case (op) inside
            OP_ADD, OP_SUB, OP_CMP, OP_POPU: f = (sp < SPW'(2));
            OP_OUT, OP_JZ, OP_JNZ, OP_POP:   f = (sp == '0);
            OP_PUSH:   f = (sp >= SPW'(STACK_DEPTH));
            OP_LSTACK: f = (sp >= SPW'(STACK_DEPTH)) || (idx >= 33'(STACK_DEPTH));
            OP_SSTACK: f = (sp == '0) || (idx >= 33'(STACK_DEPTH));
            OP_CALL:   f = (rpp >= RPW'(RROWS)) || (33'(a) > 33'(sp));
            OP_RET:    f = (rpp == '0) || (fb >= SPW'(STACK_DEPTH));
            OP_DUP:    f = (sp == '0) || (sp >= SPW'(STACK_DEPTH));
            default:   f = 1'b0;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] nrd_of(input logic [7:0] op);
        logic [1:0] n;
        case (op) inside
            OP_ADD, OP_SUB, OP_CMP: n = 2'd2;
            OP_OUT, OP_LSTACK, OP_SSTACK, OP_RET, OP_JZ, OP_JNZ, OP_POPU, OP_DUP: n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    item_t          item_reg;
    logic           hold_reg;
    logic [1:0]     nrd_reg;
    logic [1:0]     rd_cnt_reg;
    logic           live_reg;
    entry_t         opa_reg;
    entry_t         opb_reg;
    logic [RW-1:0]  ret_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [SPW-1:0] fb_reg, fb_next;
    logic [RPW-1:0] rpp_reg, rpp_next;
    logic [31:0]    pc_reg, pc_next;
    logic           run_reg, run_next;
    result_t        res_reg;
    logic           res_valid_reg;

    entry_t         smem_q, opa, opb, swdata;
    logic [RW-1:0]  rmem_q, ret, rwdata;
    logic           swe, rwe, sre, rre;
    logic [AW-1:0]  swaddr, sraddr;
    logic [RAW-1:0] rwaddr, rraddr;

    logic           exec_fire, acc, rd2_issue, ac_fault;
    logic [1:0]     ac_nrd;
    logic [32:0]    ac_idx;
    logic [SPW-1:0] ac_sp_m1;

    logic [SPW-1:0] e_sp, e_fb, sp_m1, sp_m2, sp_p1, ret_fb;
    logic [RPW-1:0] e_rpp;
    logic [31:0]    e_pc;
    logic           e_run, flt, tru, eq;
    logic [32:0]    e_idx;
    logic [31:0]    len;
    result_t        e_res;

    assign exec_fire = hold_reg && (rd_cnt_reg == nrd_reg) && (!res_valid_reg || result_ready);
    assign item_ready = !hold_reg || exec_fire;
    assign acc = item_valid && item_ready;
    assign rd2_issue = hold_reg && (nrd_reg == 2'd2) && (rd_cnt_reg == 2'd1);

    assign opa = (live_reg && rd_cnt_reg == 2'd1) ? smem_q : opa_reg;
    assign opb = (live_reg && rd_cnt_reg == 2'd2) ? smem_q : opb_reg;
    assign ret = (live_reg && rd_cnt_reg == 2'd1) ? rmem_q : ret_reg;

    assign sp_m1 = sp_reg - SPW'(1);
    assign sp_m2 = sp_reg - SPW'(2);
    assign sp_p1 = sp_reg + SPW'(1);
    assign e_idx = 33'(item_reg.operand_a) + 33'(fb_reg);
    assign ret_fb = ret[SPW-1:0];

    always_comb
    begin
        e_sp   = sp_reg;
        e_fb   = fb_reg;
        e_rpp  = rpp_reg;
        e_run  = run_reg;
        swe    = 1'b0;
        swaddr = sp_reg[AW-1:0];
        swdata = opa;
        rwe    = 1'b0;
        rwaddr = rpp_reg[RAW-1:0];
        rwdata = {pc_reg + 32'd9, fb_reg};
        e_res  = '0;
        tru    = (opa.tag == TAG_BOOL) ? (opa.val != 64'd0) : (opa.tag != TAG_NONE);
        eq     = (opa.tag != opb.tag) ? 1'b0 :
                 (opa.tag == TAG_NONE) ? 1'b1 : (opa.val == opb.val);
        flt    = fault_of(item_reg.action, item_reg.operand_a, sp_reg, fb_reg, rpp_reg);
        case (item_reg.action) inside
            OP_PUSH, OP_LSTACK, OP_SSTACK, OP_JZ, OP_JP, OP_JNZ: len = 32'd5;
            OP_CALL: len = 32'd9;
            default: len = 32'd1;
        endcase
        e_pc = pc_reg + len;
        e_res.error = ERR_OK;
        if (!run_reg)
        begin
            e_pc = pc_reg;
        end
        else if (flt)
        begin
            e_res.error = ERR_STACK;
        end
        else
        begin
            case (item_reg.action) inside
                OP_NOP: ;
                OP_ADD, OP_SUB:
                begin
                    swe    = 1'b1;
                    swaddr = sp_m2[AW-1:0];
                    e_sp   = sp_m1;
                    if (opa.tag != opb.tag)
                    begin
                        swdata = '{tag: TAG_NONE, val: 64'd0};
                        e_res.error = ERR_TYPE;
                    end
                    else if (opa.tag != TAG_INT)
                    begin
                        swdata = '{tag: TAG_NONE, val: 64'd0};
                        e_res.error = ERR_UNSUP;
                    end
                    else
                    begin
                        swdata.tag = TAG_INT;
                        swdata.val = (item_reg.action == OP_ADD) ? opa.val + opb.val
                                                                 : opa.val - opb.val;
                    end
                end
                OP_CMP:
                begin
                    swe    = 1'b1;
                    swaddr = sp_m2[AW-1:0];
                    swdata = '{tag: TAG_BOOL, val: {63'd0, eq}};
                    e_sp   = sp_m1;
                end
                OP_OUT:
                begin
                    e_res.out_valid = 1'b1;
                    e_res.out_value = opa.val;
                    e_res.out_type  = opa.tag;
                    e_sp = sp_m1;
                end
                OP_PUSH:
                begin
                    swe    = 1'b1;
                    swdata = '{tag: TAG_INT,
                               val: {{32{item_reg.const_value[31]}}, item_reg.const_value}};
                    e_sp   = sp_p1;
                end
                OP_LSTACK, OP_DUP:
                begin
                    swe  = 1'b1;
                    e_sp = sp_p1;
                end
                OP_SSTACK:
                begin
                    swe    = 1'b1;
                    swaddr = e_idx[AW-1:0];
                    e_sp   = sp_m1;
                end
                OP_CALL:
                begin
                    rwe   = 1'b1;
                    e_rpp = rpp_reg + RPW'(1);
                    e_fb  = sp_reg - item_reg.operand_a[SPW-1:0];
                    e_pc  = item_reg.operand_b;
                end
                OP_RET:
                begin
                    e_sp  = fb_reg + SPW'(1);
                    e_fb  = (ret_fb > SPW'(STACK_DEPTH)) ? SPW'(STACK_DEPTH) : ret_fb;
                    e_pc  = ret[RW-1:SPW];
                    e_rpp = rpp_reg - RPW'(1);
                end
                OP_HALT: e_run = 1'b0;
                OP_JZ, OP_JNZ:
                begin
                    e_sp = sp_m1;
                    if ((item_reg.action == OP_JZ) == tru)
                    begin
                        e_pc = item_reg.operand_a;
                    end
                end
                OP_JP: e_pc = item_reg.operand_a;
                OP_POP: e_sp = sp_m1;
                OP_POPU:
                begin
                    swe    = 1'b1;
                    swaddr = sp_m2[AW-1:0];
                    e_sp   = sp_m1;
                end
                default: e_res.error = ERR_OPCODE;
            endcase
        end
        e_res.next_pc = e_pc;
        e_res.halted  = !e_run;
        swe = swe && exec_fire;
        rwe = rwe && exec_fire;
    end

    assign sp_next  = exec_fire ? e_sp  : sp_reg;
    assign fb_next  = exec_fire ? e_fb  : fb_reg;
    assign rpp_next = exec_fire ? e_rpp : rpp_reg;
    assign pc_next  = exec_fire ? e_pc  : pc_reg;
    assign run_next = exec_fire ? e_run : run_reg;

    assign ac_fault = fault_of(item.action, item.operand_a, sp_next, fb_next, rpp_next);
    assign ac_nrd   = (run_next && !ac_fault) ? nrd_of(item.action) : 2'd0;
    assign ac_idx   = 33'(item.operand_a) + 33'(fb_next);
    assign ac_sp_m1 = sp_next - SPW'(1);

    always_comb
    begin
        sre    = rd2_issue || (acc && ac_nrd != 2'd0 && item.action != OP_RET);
        rre    = acc && ac_nrd != 2'd0 && item.action == OP_RET;
        rraddr = RAW'(rpp_next - RPW'(1));
        if (rd2_issue)
        begin
            sraddr = sp_m2[AW-1:0];
        end
        else if (item.action == OP_LSTACK)
        begin
            sraddr = ac_idx[AW-1:0];
        end
        else
        begin
            sraddr = ac_sp_m1[AW-1:0];
        end
    end

    smeu_ram #(.W($bits(entry_t)), .DEPTH(STACK_DEPTH), .AW(AW)) u_operand_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (swe),
        .wr_addr (swaddr),
        .wr_data (swdata),
        .rd_en   (sre),
        .rd_addr (sraddr),
        .rd_data (smem_q)
    );

    smeu_ram #(.W(RW), .DEPTH(RROWS), .AW(RAW)) u_return_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rwe),
        .wr_addr (rwaddr),
        .wr_data (rwdata),
        .rd_en   (rre),
        .rd_addr (rraddr),
        .rd_data (rmem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg      <= 1'b0;
            nrd_reg       <= 2'd0;
            rd_cnt_reg    <= 2'd0;
            live_reg      <= 1'b0;
            sp_reg        <= '0;
            fb_reg        <= '0;
            rpp_reg       <= '0;
            pc_reg        <= '0;
            run_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            fb_reg  <= fb_next;
            rpp_reg <= rpp_next;
            pc_reg  <= pc_next;
            run_reg <= run_next;
            if (acc)
            begin
                hold_reg   <= 1'b1;
                nrd_reg    <= ac_nrd;
                rd_cnt_reg <= (ac_nrd != 2'd0) ? 2'd1 : 2'd0;
                live_reg   <= (ac_nrd != 2'd0);
            end
            else
            begin
                if (exec_fire)
                begin
                    hold_reg <= 1'b0;
                end
                if (rd2_issue)
                begin
                    rd_cnt_reg <= 2'd2;
                end
                live_reg <= rd2_issue;
            end
            if (exec_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            item_reg <= item;
        end
        if (live_reg && rd_cnt_reg == 2'd1)
        begin
            opa_reg <= smem_q;
            ret_reg <= rmem_q;
        end
        if (live_reg && rd_cnt_reg == 2'd2)
        begin
            opb_reg <= smem_q;
        end
        if (exec_fire)
        begin
            res_reg <= e_res;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (rd_cnt_reg <= nrd_reg))
        else $error("read count passed the reads needed");
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg <= SPW'(STACK_DEPTH)) && (fb_reg <= SPW'(STACK_DEPTH)))
        else $error("stack pointer or frame base out of range");
    a_rpp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpp_reg <= RPW'(RROWS))
        else $error("return pointer out of range");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |=> !run_reg)
        else $error("machine restarted after halt");
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd2_issue && acc))
        else $error("second operand read collides with accept read");

endmodule

### tb/stack_machine_execute_unit_checker.sv
`timescale 1ns / 1ps
// Checker for stack_machine_execute_unit: watches both channels, predicts each result
// from its own copy of the machine state and compares every field. Depends on smeu_pkg.
module stack_machine_execute_unit_checker
    import smeu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      pending_count
);

    localparam int unsigned DEPTH  = SMEU_STACK_DEPTH;
    localparam int unsigned RDEPTH = SMEU_RETURN_DEPTH;

    entry_t      stack_mem [DEPTH];
    logic [31:0] ret_words [RDEPTH];
    int unsigned sp, fb, rp;
    logic [31:0] pc;
    bit          running;
    result_t     expected_results [$];

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", field, want, got, $realtime);
        fail_count++;
    endtask

    task automatic execute_instr(input item_t it, output result_t r);
        logic [7:0]  op;
        logic [31:0] a, npc, len;
        logic [63:0] cval, idx;
        entry_t      t, s;
        bit          fault, eq, tr;
        op    = it.action;
        a     = it.operand_a;
        cval  = {{32{it.const_value[31]}}, it.const_value};
        fault = 0;
        r     = '0;
        if (!running) begin
            r.next_pc = pc;
            r.halted  = 1'b1;
        end else begin
            case (op)
                OP_PUSH, OP_LSTACK, OP_SSTACK, OP_JZ, OP_JP, OP_JNZ: len = 5;
                OP_CALL: len = 9;
                default: len = 1;
            endcase
            npc = pc + len;
            case (op)
                OP_NOP: ;
                OP_ADD, OP_SUB, OP_CMP: begin
                    if (sp < 2) fault = 1;
                    else begin
                        t = stack_mem[sp - 1];
                        s = stack_mem[sp - 2];
                        if (op == OP_CMP) begin
                            if (t.tag != s.tag) eq = 0;
                            else if (t.tag == TAG_NONE) eq = 1;
                            else eq = (t.val == s.val);
                            stack_mem[sp - 2] = '{TAG_BOOL, {63'd0, eq}};
                        end else if (t.tag != s.tag) begin
                            stack_mem[sp - 2] = '{TAG_NONE, 64'd0};
                            r.error = ERR_TYPE;
                        end else if (t.tag != TAG_INT) begin
                            stack_mem[sp - 2] = '{TAG_NONE, 64'd0};
                            r.error = ERR_UNSUP;
                        end else begin
                            stack_mem[sp - 2] = '{TAG_INT,
                                (op == OP_ADD) ? t.val + s.val : t.val - s.val};
                        end
                        sp--;
                    end
                end
                OP_OUT: begin
                    if (sp < 1) fault = 1;
                    else begin
                        r.out_valid = 1'b1;
                        r.out_type  = stack_mem[sp - 1].tag;
                        r.out_value = stack_mem[sp - 1].val;
                        sp--;
                    end
                end
                OP_PUSH: begin
                    if (sp >= DEPTH) fault = 1;
                    else begin
                        stack_mem[sp] = '{TAG_INT, cval};
                        sp++;
                    end
                end
                OP_LSTACK: begin
                    idx = 64'(fb) + 64'(a);
                    if (sp >= DEPTH || idx >= DEPTH) fault = 1;
                    else begin
                        stack_mem[sp] = stack_mem[idx];
                        sp++;
                    end
                end
                OP_SSTACK: begin
                    idx = 64'(fb) + 64'(a);
                    if (sp < 1 || idx >= DEPTH) fault = 1;
                    else begin
                        sp--;
                        stack_mem[idx] = stack_mem[sp];
                    end
                end
                OP_CALL: begin
                    if (rp + 2 > RDEPTH || a > sp) fault = 1;
                    else begin
                        ret_words[rp]     = pc + 9;
                        ret_words[rp + 1] = fb;
                        rp += 2;
                        fb  = sp - a;
                        npc = it.operand_b;
                    end
                end
                OP_RET: begin
                    if (rp < 2 || fb + 1 > DEPTH) fault = 1;
                    else begin
                        sp  = fb + 1;
                        fb  = ret_words[rp - 1];
                        npc = ret_words[rp - 2];
                        rp -= 2;
                        if (fb > DEPTH) fb = DEPTH;
                    end
                end
                OP_HALT: running = 0;
                OP_JZ, OP_JNZ: begin
                    if (sp < 1) fault = 1;
                    else begin
                        t  = stack_mem[sp - 1];
                        tr = (t.tag == TAG_BOOL) ? (t.val != 0) : (t.tag != TAG_NONE);
                        sp--;
                        if ((op == OP_JZ) == tr) npc = a;
                    end
                end
                OP_JP: npc = a;
                OP_POP: begin
                    if (sp < 1) fault = 1;
                    else sp--;
                end
                OP_POPU: begin
                    if (sp < 2) fault = 1;
                    else begin
                        stack_mem[sp - 2] = stack_mem[sp - 1];
                        sp--;
                    end
                end
                OP_DUP: begin
                    if (sp < 1 || sp >= DEPTH) fault = 1;
                    else begin
                        stack_mem[sp] = stack_mem[sp - 1];
                        sp++;
                    end
                end
                default: r.error = ERR_OPCODE;
            endcase
            if (fault) begin
                r.error     = ERR_STACK;
                npc         = pc + len;
                r.out_valid = 0;
                r.out_type  = '0;
                r.out_value = '0;
            end
            pc        = npc;
            r.next_pc = npc;
            r.halted  = !running;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want, predicted;
        if (!rst_n) begin
            sp      = 0;
            fb      = 0;
            rp      = 0;
            pc      = '0;
            running = 1;
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end else begin
            if (item_valid && item_ready) begin
                execute_instr(item, predicted);
                expected_results.insert(expected_results.size(), predicted);
            end
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (result.next_pc !== want.next_pc)
                        report("next_pc", want.next_pc, result.next_pc);
                    if (result.out_valid !== want.out_valid)
                        report("out_valid", want.out_valid, result.out_valid);
                    if (result.out_value !== want.out_value)
                        report("out_value", want.out_value, result.out_value);
                    if (result.out_type !== want.out_type)
                        report("out_type", want.out_type, result.out_type);
                    if (result.halted !== want.halted)
                        report("halted", want.halted, result.halted);
                    if (result.error !== want.error)
                        report("error", want.error, result.error);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the stack_machine_execute_unit testbench: clock, reset, instruction stimulus,
// random stalls and the verdict. Depends on smeu_pkg, the DUT and the checker.
module testbench;
    import smeu_pkg::*;

    logic    clk = 0;
    logic    rst_n = 0;
    logic    item_valid = 0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 0;
    result_t result;
    int      fail_count, pending_count;
    int      cycles = 0;
    bit      no_idle = 0;

    localparam int CYCLE_LIMIT = 400000;

    always #4 clk = ~clk;

    stack_machine_execute_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    stack_machine_execute_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                result_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic send_instr(input logic [7:0] op, input logic [31:0] a = 0,
                              input logic [31:0] b = 0, input logic [31:0] c = 0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        item       <= '{op, a, b, c};
        item_valid <= 1;
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic send_random_instr();
        int          pick;
        logic [7:0]  op;
        logic [31:0] a, c;
        pick = $urandom_range(0, 99);
        if      (pick < 22) op = OP_PUSH;
        else if (pick < 28) op = OP_ADD;
        else if (pick < 33) op = OP_SUB;
        else if (pick < 40) op = OP_CMP;
        else if (pick < 45) op = OP_OUT;
        else if (pick < 52) op = OP_LSTACK;
        else if (pick < 57) op = OP_SSTACK;
        else if (pick < 62) op = OP_CALL;
        else if (pick < 67) op = OP_RET;
        else if (pick < 71) op = OP_JZ;
        else if (pick < 75) op = OP_JNZ;
        else if (pick < 78) op = OP_JP;
        else if (pick < 83) op = OP_POP;
        else if (pick < 87) op = OP_POPU;
        else if (pick < 94) op = OP_DUP;
        else if (pick < 96) op = OP_NOP;
        else op = 8'($urandom_range(17, 255));
        a = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 12);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom();
        send_instr(op, a, $urandom(), c);
    endtask

    initial
    begin
        rst_n <= 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty-stack underflow and unknown opcodes
        send_instr(OP_ADD);
        send_instr(OP_OUT);
        send_instr(OP_POPU);
        send_instr(OP_DUP);
        send_instr(OP_JZ, 32'h40);
        send_instr(OP_SSTACK, 0);
        send_instr(OP_RET);
        send_instr(8'd17);
        send_instr(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_instr(OP_NOP);
        // value extremes, tag errors, booleans and none
        send_instr(OP_PUSH, 0, 0, 32'h7FFF_FFFF);
        send_instr(OP_PUSH, 0, 0, 32'h8000_0000);
        send_instr(OP_SUB);
        send_instr(OP_DUP);
        send_instr(OP_CMP);
        send_instr(OP_JNZ, 32'h100);
        send_instr(OP_PUSH, 0, 0, 32'hFFFF_FFFF);
        send_instr(OP_DUP);
        send_instr(OP_CMP);
        send_instr(OP_DUP);
        send_instr(OP_ADD);
        send_instr(OP_ADD);
        send_instr(OP_OUT);
        send_instr(OP_JP, 32'hFFFF_FFFF);
        send_instr(OP_SSTACK, 32'hFFFF_FFFF);

        // fill the whole operand stack, then run into overflow
        no_idle = 1;
        repeat (1030) send_instr(OP_PUSH, 0, 0, $urandom());
        no_idle = 0;
        send_instr(OP_DUP);
        send_instr(OP_LSTACK, 0);
        send_instr(OP_CALL, 32'hFFFF_FFFF, 32'h20);
        send_instr(OP_CALL, 1018, 32'h200);
        send_instr(OP_LSTACK, 32'hFFFF_FFFF);
        send_instr(OP_RET);

        for (int i = 0; i < 550; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random_instr();
        end
        no_idle = 0;

        send_instr(OP_HALT);
        repeat (4) send_random_instr();
        item_valid <= 0;

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### stack_machine_execute_unit.f
src/smeu_pkg.sv
src/smeu_ram.sv
src/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_checker.sv
tb/testbench.sv
